// File: src/tpmeq_pkg.sv
`timescale 1ns / 1ps
package tpmeq_pkg;
  localparam int MAX_NODES  = 1024;
  localparam int LOG_LEVELS = 10;
  localparam int NODE_W     = 10;
  localparam int LV_W       = 4;
  localparam int CNT_W      = 11;
  localparam int WEIGHT_W   = 31;
  localparam int DEPTH_W    = 10;
  localparam int ADDR_W     = LV_W + NODE_W;
  localparam int JUMP_DEPTH = LOG_LEVELS * MAX_NODES;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_B_STEP = 11'b00000000010,
    S_B_RD   = 11'b00000000100,
    S_B_WR   = 11'b00000001000,
    S_Q_DEP  = 11'b00000010000,
    S_Q_SWAP = 11'b00000100000,
    S_U_ISS  = 11'b00001000000,
    S_U_EVAL = 11'b00010000000,
    S_L_ISS  = 11'b00100000000,
    S_L_EVAL = 11'b01000000000,
    S_F_EVAL = 11'b10000000000
  } state_t;
endpackage

// File: src/tree_path_max_edge_query_unit.sv
`timescale 1ns / 1ps
// Channel  | Ports                                                      | Handshake
// input    | in_opcode in_node in_other_node in_parent in_is_root ...   | start & !busy
// result   | out_max_weight out_same_node                               | out_valid pulse
// config   | cfg_wdata                                                  | cfg_we
// A load transaction completes in the accepting cycle. A build sweeps all levels and
// nodes of the jump memories; a filled entry passes through S_B_STEP, S_B_RD and S_B_WR.
// A query reads both depths, climbs the deeper node and, unless the nodes then match, climbs
// both jointly and ends in S_F_EVAL, each climb with an issue and an evaluate state per level.
// Reset (synchronous, rst_n low) returns the controller to idle and count_r to 1.
// The result is held for one cycle under out_valid; the receiver cannot stall it.
module tree_path_max_edge_query_unit
  import tpmeq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic [NODE_W-1:0]   in_node,
  input  logic [NODE_W-1:0]   in_other_node,
  input  logic [NODE_W-1:0]   in_parent,
  input  logic                in_is_root,
  input  logic [WEIGHT_W-1:0] in_edge_weight,
  input  logic [DEPTH_W-1:0]  in_depth,
  output logic                out_valid,
  output logic [WEIGHT_W-1:0] out_max_weight,
  output logic                out_same_node,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata
);

  logic [NODE_W:0]        anc_mem [0:JUMP_DEPTH-1];
  logic [WEIGHT_W-1:0]    wt_mem  [0:JUMP_DEPTH-1];
  logic [DEPTH_W-1:0]     dep_mem [0:MAX_NODES-1];

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r;
  logic [LV_W-1:0]        lv_r, lv_nxt;
  logic [NODE_W-1:0]      idx_r, idx_nxt;
  logic [NODE_W-1:0]      p_r, p_nxt, q_r, q_nxt;
  logic [DEPTH_W-1:0]     dq_r, dq_nxt;
  logic [WEIGHT_W-1:0]    res_r, res_nxt;
  logic                   any_r, any_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WEIGHT_W-1:0]    out_max_r, out_max_nxt;
  logic                   out_same_r, out_same_nxt;

  logic [NODE_W:0]        anc_a_r, anc_b_r;
  logic [WEIGHT_W-1:0]    wt_a_r, wt_b_r;
  logic [DEPTH_W-1:0]     dep_a_r, dep_b_r;

  logic [ADDR_W-1:0]      ra_addr, rb_addr, wr_addr;
  logic                   jump_we, dep_we;
  logic [NODE_W:0]        anc_wd;
  logic [WEIGHT_W-1:0]    wt_wd;
  logic [NODE_W-1:0]      da_addr, db_addr;

  logic                   accept;
  logic [CNT_W-1:0]       n_used;
  logic [LV_W-1:0]        top;
  logic [LV_W-1:0]        lv_m1;
  logic                   idx_in;
  logic                   last_idx;
  logic [DEPTH_W+1:0]     need;
  logic [WEIGHT_W-1:0]    wab_max;

  function automatic logic [WEIGHT_W-1:0] umax(input logic [WEIGHT_W-1:0] a,
                                               input logic [WEIGHT_W-1:0] b);
    umax = (a > b) ? a : b;
  endfunction

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    if (count_r == '0) begin
      n_used = CNT_W'(1);
    end else if (count_r > CNT_W'(MAX_NODES)) begin
      n_used = CNT_W'(MAX_NODES);
    end else begin
      n_used = count_r;
    end
  end

  // Highest level tried: floor(log2(count)), capped at the top table level.
  always_comb begin
    top = '0;
    for (int k = 1; k < LOG_LEVELS; k++) begin
      if ((n_used >> k) != '0) begin
        top = LV_W'(k);
      end
    end
  end

  assign lv_m1    = lv_r - LV_W'(1);
  assign idx_in   = ({1'b0, idx_r} < n_used);
  assign last_idx = (idx_r == NODE_W'(MAX_NODES - 1));
  assign need     = {2'b00, dq_r} + ((DEPTH_W+2)'(1) << lv_r);
  assign wab_max  = umax(wt_a_r, wt_b_r);

  // Read address selection.
  always_comb begin
    ra_addr = '0;
    rb_addr = '0;
    da_addr = p_r;
    db_addr = q_r;
    unique case (state_r)
      S_B_STEP, S_B_RD, S_B_WR: begin
        ra_addr = {lv_m1, idx_r};
        rb_addr = {lv_m1, anc_a_r[NODE_W-1:0]};
      end
      S_U_ISS, S_U_EVAL: begin
        ra_addr = {lv_r, p_r};
      end
      S_L_ISS: begin
        ra_addr = {lv_r, p_r};
        rb_addr = {lv_r, q_r};
      end
      S_L_EVAL: begin
        // Level 0 of the nodes reached by this step feeds the final cycle.
        ra_addr = {LV_W'(0), p_nxt};
        rb_addr = {LV_W'(0), q_nxt};
      end
      S_F_EVAL: begin
        ra_addr = {LV_W'(0), p_r};
        rb_addr = {LV_W'(0), q_r};
      end
      default: begin
        ra_addr = '0;
        rb_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (jump_we) begin
      anc_mem[wr_addr] <= anc_wd;
      wt_mem[wr_addr]  <= wt_wd;
    end
    anc_a_r <= anc_mem[ra_addr];
    anc_b_r <= anc_mem[rb_addr];
    wt_a_r  <= wt_mem[ra_addr];
    wt_b_r  <= wt_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[in_node] <= in_depth;
    end
    dep_a_r <= dep_mem[da_addr];
    dep_b_r <= dep_mem[db_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    lv_nxt        = lv_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    dq_nxt        = dq_r;
    res_nxt       = res_r;
    any_nxt       = any_r;
    out_valid_nxt = 1'b0;
    out_max_nxt   = out_max_r;
    out_same_nxt  = out_same_r;
    jump_we       = 1'b0;
    dep_we        = 1'b0;
    wr_addr       = {lv_r, idx_r};
    anc_wd        = '0;
    wt_wd         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_LOAD: begin
              jump_we = 1'b1;
              dep_we  = 1'b1;
              wr_addr = {LV_W'(0), in_node};
              if (!in_is_root) begin
                anc_wd = {1'b1, in_parent};
                wt_wd  = in_edge_weight;
              end
            end
            OP_BUILD: begin
              lv_nxt    = '0;
              idx_nxt   = '0;
              state_nxt = S_B_STEP;
            end
            OP_QUERY: begin
              p_nxt     = in_node;
              q_nxt     = in_other_node;
              state_nxt = S_Q_DEP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_B_STEP, S_B_WR: begin
        if (state_r == S_B_STEP && lv_r == '0 && idx_in) begin
          jump_we = 1'b0;
        end else if (state_r == S_B_STEP && lv_r != '0 && idx_in &&
                     ((CNT_W'(1) << lv_r) < n_used)) begin
          state_nxt = S_B_RD;
        end else begin
          // Either a filled entry or one that becomes "no ancestor".
          jump_we = 1'b1;
          if (state_r == S_B_WR && anc_a_r[NODE_W]) begin
            anc_wd = anc_b_r;
            wt_wd  = wab_max;
          end
        end
        if (state_nxt != S_B_RD) begin
          if (last_idx) begin
            idx_nxt = '0;
            if (lv_r == LV_W'(LOG_LEVELS - 1)) begin
              state_nxt = S_IDLE;
            end else begin
              lv_nxt    = lv_r + LV_W'(1);
              state_nxt = S_B_STEP;
            end
          end else begin
            idx_nxt   = idx_r + NODE_W'(1);
            state_nxt = S_B_STEP;
          end
        end
      end

      S_B_RD: begin
        state_nxt = S_B_WR;
      end

      S_Q_DEP: begin
        state_nxt = S_Q_SWAP;
      end

      S_Q_SWAP: begin
        // The deeper node climbs first.
        if (dep_a_r < dep_b_r) begin
          p_nxt  = q_r;
          q_nxt  = p_r;
          dq_nxt = dep_a_r;
        end else begin
          dq_nxt = dep_b_r;
        end
        lv_nxt    = top;
        res_nxt   = '0;
        any_nxt   = 1'b0;
        state_nxt = S_U_ISS;
      end

      S_U_ISS: begin
        state_nxt = S_U_EVAL;
      end

      S_U_EVAL: begin
        if ({2'b00, dep_a_r} >= need && anc_a_r[NODE_W]) begin
          res_nxt = umax(res_r, wt_a_r);
          any_nxt = 1'b1;
          p_nxt   = anc_a_r[NODE_W-1:0];
        end
        if (lv_r == '0) begin
          if (p_nxt != q_r) begin
            lv_nxt    = top;
            state_nxt = S_L_ISS;
          end else begin
            out_valid_nxt = 1'b1;
            out_max_nxt   = res_nxt;
            out_same_nxt  = !any_nxt;
            state_nxt     = S_IDLE;
          end
        end else begin
          lv_nxt    = lv_r - LV_W'(1);
          state_nxt = S_U_ISS;
        end
      end

      S_L_ISS: begin
        state_nxt = S_L_EVAL;
      end

      S_L_EVAL: begin
        if (anc_a_r[NODE_W] && anc_b_r[NODE_W] && anc_a_r != anc_b_r) begin
          res_nxt = umax(res_r, wab_max);
          p_nxt   = anc_a_r[NODE_W-1:0];
          q_nxt   = anc_b_r[NODE_W-1:0];
        end
        if (lv_r == '0) begin
          state_nxt = S_F_EVAL;
        end else begin
          lv_nxt    = lv_r - LV_W'(1);
          state_nxt = S_L_ISS;
        end
      end

      S_F_EVAL: begin
        // Port reads of level 0 for the final p and q were issued last cycle.
        res_nxt       = umax(res_r, wab_max);
        out_valid_nxt = 1'b1;
        out_max_nxt   = res_nxt;
        out_same_nxt  = 1'b0;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lv_r       <= lv_nxt;
    idx_r      <= idx_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    dq_r       <= dq_nxt;
    res_r      <= res_nxt;
    any_r      <= any_nxt;
    out_max_r  <= out_max_nxt;
    out_same_r <= out_same_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_max_weight = out_max_r;
  assign out_same_node  = out_same_r;

endmodule

// File: bench/tpmeq_checker.sv
`timescale 1ns / 1ps
module tpmeq_checker
  import tpmeq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic [NODE_W-1:0]   in_node,
  input  logic [NODE_W-1:0]   in_other_node,
  input  logic [NODE_W-1:0]   in_parent,
  input  logic                in_is_root,
  input  logic [WEIGHT_W-1:0] in_edge_weight,
  input  logic [DEPTH_W-1:0]  in_depth,
  input  logic                out_valid,
  input  logic [WEIGHT_W-1:0] out_max_weight,
  input  logic                out_same_node,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata,
  output int                  mismatches,
  output int                  outstanding,
  output int                  answered
);
  typedef struct packed {
    logic [WEIGHT_W-1:0] max_weight;
    logic                same_node;
  } answer_t;

  // Ancestor entries carry a valid bit above the node index.
  logic [NODE_W:0]     ancestor [LOG_LEVELS][MAX_NODES];
  logic [WEIGHT_W-1:0] hop_max  [LOG_LEVELS][MAX_NODES];
  logic [DEPTH_W-1:0]  depth_of [MAX_NODES];
  logic [CNT_W-1:0]    node_count;
  answer_t             answers_due [$];

  function automatic int clamped_count();
    int n;
    n = int'(node_count);
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  function automatic logic [WEIGHT_W-1:0] wmax(logic [WEIGHT_W-1:0] a, logic [WEIGHT_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  task automatic rebuild_jumps();
    int n;
    int a;
    bit fill;
    n = clamped_count();
    for (int j = 0; j < LOG_LEVELS; j++) begin
      fill = (j >= 1) && ((1 << j) < n);
      for (int i = 0; i < MAX_NODES; i++) begin
        if (i < n && j == 0) continue;
        if (i < n && fill && ancestor[j-1][i][NODE_W]) begin
          a = int'(ancestor[j-1][i][NODE_W-1:0]);
          ancestor[j][i] = ancestor[j-1][a];
          hop_max[j][i]  = wmax(hop_max[j-1][i], hop_max[j-1][a]);
        end else begin
          ancestor[j][i] = '0;
          hop_max[j][i]  = '0;
        end
      end
    end
  endtask

  function automatic answer_t path_answer(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    logic [NODE_W-1:0]   p, q, t;
    logic [NODE_W:0]     ep, eq;
    logic [WEIGHT_W-1:0] best;
    bit                  climbed;
    int                  top_lv, n;
    answer_t             r;
    n = clamped_count();
    p = a;
    q = b;
    best = '0;
    climbed = 0;
    top_lv = 0;
    while (top_lv + 1 < LOG_LEVELS && (2 << top_lv) <= n) top_lv++;
    if (depth_of[p] < depth_of[q]) begin
      t = p; p = q; q = t;
    end
    // Bring the deeper node up to the depth of the other one.
    for (int lv = top_lv; lv >= 0; lv--) begin
      ep = ancestor[lv][p];
      if (int'(depth_of[p]) - (1 << lv) >= int'(depth_of[q]) && ep[NODE_W]) begin
        best = wmax(best, hop_max[lv][p]);
        climbed = 1;
        p = ep[NODE_W-1:0];
      end
    end
    if (p != q) begin
      for (int lv = top_lv; lv >= 0; lv--) begin
        ep = ancestor[lv][p];
        eq = ancestor[lv][q];
        if (ep[NODE_W] && eq[NODE_W] && ep != eq) begin
          best = wmax(best, wmax(hop_max[lv][p], hop_max[lv][q]));
          p = ep[NODE_W-1:0];
          q = eq[NODE_W-1:0];
        end
      end
      best = wmax(best, wmax(hop_max[0][p], hop_max[0][q]));
      climbed = 1;
    end
    r.max_weight = climbed ? best : '0;
    r.same_node  = !climbed;
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t exp_r;
    if (!rst_n) begin
      node_count = CNT_W'(1);
      answers_due.delete();
      for (int j = 0; j < LOG_LEVELS; j++)
        for (int i = 0; i < MAX_NODES; i++) begin
          ancestor[j][i] = '0;
          hop_max[j][i]  = '0;
        end
      for (int i = 0; i < MAX_NODES; i++) depth_of[i] = '0;
    end else begin
      if (out_valid) begin
        answered++;
        if (answers_due.size() == 0) begin
          $error("unexpected result: max_weight %0d same_node %0d",
                 out_max_weight, out_same_node);
          mismatches++;
        end else begin
          exp_r = answers_due.pop_front();
          if (out_max_weight !== exp_r.max_weight) begin
            $error("max_weight expected %0d actual %0d", exp_r.max_weight, out_max_weight);
            mismatches++;
          end
          if (out_same_node !== exp_r.same_node) begin
            $error("same_node expected %0d actual %0d", exp_r.same_node, out_same_node);
            mismatches++;
          end
        end
      end
      if (cfg_we) node_count = cfg_wdata;
      if (start && !busy) begin
        case (in_opcode)
          OP_LOAD: begin
            if (in_is_root) begin
              ancestor[0][in_node] = '0;
              hop_max[0][in_node]  = '0;
            end else begin
              ancestor[0][in_node] = {1'b1, in_parent};
              hop_max[0][in_node]  = in_edge_weight;
            end
            depth_of[in_node] = in_depth;
          end
          OP_BUILD: rebuild_jumps();
          OP_QUERY: answers_due = {answers_due, path_answer(in_node, in_other_node)};
          default: ;
        endcase
      end
    end
    outstanding = answers_due.size();
  end

  initial begin
    mismatches  = 0;
    outstanding = 0;
    answered    = 0;
  end
endmodule

// File: bench/tree_path_max_edge_query_unit_tb.sv
`timescale 1ns / 1ps
module tree_path_max_edge_query_unit_tb;
  import tpmeq_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                start = 0;
  logic                busy;
  logic [1:0]          in_opcode = OP_LOAD;
  logic [NODE_W-1:0]   in_node = '0;
  logic [NODE_W-1:0]   in_other_node = '0;
  logic [NODE_W-1:0]   in_parent = '0;
  logic                in_is_root = 0;
  logic [WEIGHT_W-1:0] in_edge_weight = '0;
  logic [DEPTH_W-1:0]  in_depth = '0;
  logic                out_valid;
  logic [WEIGHT_W-1:0] out_max_weight;
  logic                out_same_node;
  logic                cfg_we = 0;
  logic [CNT_W-1:0]    cfg_wdata = '0;
  int                  mismatches, outstanding, answered;

  // Nodes whose depth has been loaded; only these are ever queried or drawn as non-chain parents.
  bit                  known [MAX_NODES];
  int                  known_list [$];
  int                  tree_depth [MAX_NODES];
  int                  items_sent, queries_sent, builds_sent, stall_cycles;

  tree_path_max_edge_query_unit dut (.*);

  tpmeq_checker chk (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return WEIGHT_W'($urandom_range(0, 15));
      1: return {1'b1, 30'($urandom)};
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic int pick_known();
    return known_list[$urandom_range(0, known_list.size() - 1)];
  endfunction

  task automatic send(logic [1:0] op, int nd, int other, int par, bit root,
                      logic [WEIGHT_W-1:0] w, int dep, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    while (busy) begin
      start <= 0;
      @(negedge clk);
    end
    start          <= 1;
    in_opcode      <= op;
    in_node        <= NODE_W'(nd);
    in_other_node  <= NODE_W'(other);
    in_parent      <= NODE_W'(par);
    in_is_root     <= root;
    in_edge_weight <= w;
    in_depth       <= DEPTH_W'(dep);
    items_sent++;
    if (op == OP_QUERY) queries_sent++;
    if (op == OP_BUILD) builds_sent++;
  endtask

  task automatic load_node(int nd, int par, bit root, logic [WEIGHT_W-1:0] w, int dep);
    send(OP_LOAD, nd, $urandom_range(0, 1023), par, root, w, dep, pick_gap());
    tree_depth[nd] = dep;
    if (!known[nd]) begin
      known[nd] = 1;
      known_list = {known_list, nd};
    end
  endtask

  task automatic query(int a, int b);
    send(OP_QUERY, a, b, $urandom_range(0, 1023), 1'($urandom_range(0, 1)),
         WEIGHT_W'($urandom), $urandom_range(0, 1023), pick_gap());
  endtask

  task automatic build();
    send(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
         $urandom_range(0, 1023), 1'($urandom_range(0, 1)), WEIGHT_W'($urandom),
         $urandom_range(0, 1023), pick_gap());
  endtask

  // Waits until every answer is in and a full query latency has passed, then sets the count.
  task automatic set_count(int n);
    @(negedge clk);
    start <= 0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we    <= 1;
    cfg_wdata <= CNT_W'(n);
    @(negedge clk);
    cfg_we    <= 0;
  endtask

  // Loads a tree over nodes lo..hi (node 0 as root); each other parent is i-1 in chain mode, else a known node.
  task automatic grow_tree(int lo, int hi, bit chain);
    int par;
    for (int i = lo; i <= hi; i++) begin
      if (i == 0) begin
        load_node(0, $urandom_range(0, 1023), 1, pick_weight(), 0);
      end else begin
        par = chain ? i - 1 : pick_known();
        load_node(i, par, 0, pick_weight(), (tree_depth[par] + 1) % 1024);
      end
    end
  endtask

  task automatic random_traffic(int count);
    int r, nd, par;
    bit built;
    built = 0;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        query(pick_known(), pick_known());
      end else if (r < 74) begin
        nd = pick_known();
        query(nd, nd);
      end else if (r < 88) begin
        nd  = $urandom_range(0, 1023);
        par = pick_known();
        if ($urandom_range(0, 4) == 0)
          load_node(nd, par, 1'($urandom_range(0, 1)), pick_weight(),
                    $urandom_range(0, 1023));
        else
          load_node(nd, par, 0, pick_weight(), (tree_depth[par] + 1) % 1024);
      end else if (r < 93) begin
        send(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 1023), 1'($urandom_range(0, 1)), WEIGHT_W'($urandom),
             $urandom_range(0, 1023), pick_gap());
      end else if (!built && r < 95) begin
        build();
        built = 1;
      end else begin
        query(pick_known(), pick_known());
      end
    end
  endtask

  initial begin
    int counts [8] = '{1, 2, 0, 2047, 1024, 3, 17, 100};
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: a small tree with extreme weights, root records and the top node index.
    set_count(8);
    load_node(0, 1023, 1, 31'h7FFF_FFFF, 0);
    load_node(1, 0, 0, 31'h7FFF_FFFF, 1);
    load_node(2, 0, 0, 0, 1);
    load_node(3, 1, 0, 5, 2);
    load_node(4, 3, 0, 9, 3);
    load_node(5, 2, 0, 31'h4000_0000, 2);
    load_node(6, 5, 0, 1, 3);
    load_node(7, 6, 0, 2, 4);
    load_node(1023, 7, 0, 31'h2AAA_AAAA, 5);
    load_node(1000, 1023, 0, 31'h5555_5555, 10'h3FF);
    send(OP_UNUSED, 1023, 1023, 1023, 1, 31'h7FFF_FFFF, 1023, 0);
    build();
    query(4, 4);
    query(4, 7);
    query(7, 4);
    query(1, 2);
    query(1023, 0);
    query(0, 1023);
    query(3, 1);
    query(5, 0);
    query(1000, 4);
    query(6, 1000);

    foreach (counts[c]) begin
      set_count(counts[c]);
      n = (counts[c] < 1) ? 1 : (counts[c] > MAX_NODES ? MAX_NODES : counts[c]);
      grow_tree(0, (n < 40 ? n : 40) - 1, 0);
      build();
      random_traffic(80);
    end

    // A long chain so that the upper jump levels are reached.
    set_count(1024);
    grow_tree(200, 360, 1);
    build();
    random_traffic(60);

    @(negedge clk);
    start <= 0;
    while (outstanding != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d transactions: %0d queries, %0d table builds.",
             items_sent, queries_sent, builds_sent);
    $display("Checked %0d results over node counts from 0 to 2047.", answered);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// File: sim.f
src/tpmeq_pkg.sv
src/tree_path_max_edge_query_unit.sv
bench/tpmeq_checker.sv
bench/tree_path_max_edge_query_unit_tb.sv
